### hw/rtl/packet_deframer_router_top_defines.svh
// ----------------------------------------------------------------------------
// Packet deframer/router assertion macros
// Shared concurrent assertion wrappers for the checker.
// ----------------------------------------------------------------------------
`ifndef PACKET_DEFRAMER_ROUTER_TOP_DEFINES_SVH
`define PACKET_DEFRAMER_ROUTER_TOP_DEFINES_SVH

// Assertion sampled on the rising clock, off while reset is held
`define PDR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("pdr assertion failed");

// Assertion that also holds during reset
`define PDR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pdr assertion failed");

`endif

### hw/rtl/pdr_pkg.sv
// ----------------------------------------------------------------------------
// pdr_pkg
// Shared constants and types of the packet deframer/router.
// ----------------------------------------------------------------------------
package pdr_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_DATA_DEF  = 32;
  localparam int unsigned NUM_PORTS_DEF = 4;

  // Per-port state slots (port field is 2 bits wide)
  localparam int unsigned PORT_SLOTS = 4;

  // CRC-8 polynomial
  localparam logic [7:0] CRC_POLY = 8'h07;

  // Result kinds
  localparam logic [1:0] KIND_LOCAL = 2'd0;
  localparam logic [1:0] KIND_FWD   = 2'd1;
  localparam logic [1:0] KIND_REPLY = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_NODE_ID   = 3'd0;
  localparam logic [2:0] REG_BCAST_ID  = 3'd1;
  localparam logic [2:0] REG_HEADER    = 3'd2;
  localparam logic [2:0] REG_REPLY_TTL = 3'd3;
  localparam logic [2:0] REG_ERR_CMD   = 3'd4;
  localparam logic [2:0] REG_TTL_CODE  = 3'd5;

  // Parser phases
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_TARGET = 3'd1;
  localparam logic [2:0] PH_SOURCE = 3'd2;
  localparam logic [2:0] PH_TTL    = 3'd3;
  localparam logic [2:0] PH_CMD    = 3'd4;
  localparam logic [2:0] PH_LEN    = 3'd5;
  localparam logic [2:0] PH_DATA   = 3'd6;
  localparam logic [2:0] PH_CRC    = 3'd7;

  // Length field of an error reply
  localparam logic [7:0] REPLY_LEN = 8'd2;

endpackage

### hw/rtl/pdr_crc8.sv
// ----------------------------------------------------------------------------
// pdr_crc8
// One-byte CRC-8 update (poly 0x07, MSB first), shared by parser and emitter.
// ----------------------------------------------------------------------------
module pdr_crc8 (
  input  logic [7:0] crc_i,
  input  logic [7:0] byte_i,
  output logic [7:0] crc_o
);

  logic [7:0] c;

  // Eight shift/xor steps on the byte
  always_comb begin
    c = crc_i ^ byte_i;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ pdr_pkg::CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    crc_o = c;
  end

endmodule

### hw/rtl/pdr_store.sv
// ----------------------------------------------------------------------------
// pdr_store
// Packet byte store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pdr_store #(
  parameter int unsigned DEPTH = 156,
  parameter int unsigned AW    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/packet_deframer_router_top.sv
// ----------------------------------------------------------------------------
// packet_deframer_router_top
// Four-port packet deframer with CRC-8 check, local delivery and forwarding.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake              | payload
//  s_axis    | in  | tvalid/tready          | tuser: port, tdata: rx_byte
//  m_axis    | out | tvalid/tready, tlast   | tuser: kind, tdata: result fields
//  apb       | in  | psel/penable, pready=1 | six 8-bit registers at 4*i
//
// A byte that does not finish a packet leaves the input ready for more bytes.
// A good CRC byte starts the emitter: it reads the packet header from the store,
// decides, then gives each result word by store read, format and present, plus
// any output stall; input is not taken until the last word leaves or the packet
// is dropped. The store's single read port gives each word its own read step.
// Reset clears parser state, sets register defaults; the store needs no clearing.
// ----------------------------------------------------------------------------
module packet_deframer_router_top #(
  parameter int unsigned MAX_DATA  = pdr_pkg::MAX_DATA_DEF,
  parameter int unsigned NUM_PORTS = pdr_pkg::NUM_PORTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] port
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // out_port, out_byte, target, sender_id,
                                      // command, payload_len, payload_index,
                                      // payload_byte, zero pad
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned SLOT_LEN = MAX_DATA + 7;
  localparam int unsigned DEPTH    = NUM_PORTS * SLOT_LEN;
  localparam int unsigned AW       = $clog2(DEPTH);
  localparam int unsigned BCW      = $clog2(SLOT_LEN + 1);
  localparam int unsigned IW       = $clog2(SLOT_LEN);

  typedef enum logic [2:0] {
    S_IDLE, S_HRD, S_HLAT, S_DECIDE, S_RD, S_LAT, S_OUT
  } state_e;

  // ---------------- configuration registers ----------------
  logic [7:0] node_id_q, bcast_q, header_q, reply_ttl_q, err_cmd_q, ttl_code_q;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q   <= 8'd1;
      bcast_q     <= 8'd255;
      header_q    <= 8'd170;
      reply_ttl_q <= 8'd8;
      err_cmd_q   <= 8'd255;
      ttl_code_q  <= 8'd1;
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        pdr_pkg::REG_NODE_ID:   node_id_q   <= pwdata[7:0];
        pdr_pkg::REG_BCAST_ID:  bcast_q     <= pwdata[7:0];
        pdr_pkg::REG_HEADER:    header_q    <= pwdata[7:0];
        pdr_pkg::REG_REPLY_TTL: reply_ttl_q <= pwdata[7:0];
        pdr_pkg::REG_ERR_CMD:   err_cmd_q   <= pwdata[7:0];
        pdr_pkg::REG_TTL_CODE:  ttl_code_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (paddr[4:2])
      pdr_pkg::REG_NODE_ID:   prdata = {24'd0, node_id_q};
      pdr_pkg::REG_BCAST_ID:  prdata = {24'd0, bcast_q};
      pdr_pkg::REG_HEADER:    prdata = {24'd0, header_q};
      pdr_pkg::REG_REPLY_TTL: prdata = {24'd0, reply_ttl_q};
      pdr_pkg::REG_ERR_CMD:   prdata = {24'd0, err_cmd_q};
      pdr_pkg::REG_TTL_CODE:  prdata = {24'd0, ttl_code_q};
      default:                prdata = 32'd0;
    endcase
  end

  // ---------------- per-port parser state ----------------
  logic [2:0]     phase_q    [pdr_pkg::PORT_SLOTS];
  logic [BCW-1:0] bcount_q   [pdr_pkg::PORT_SLOTS];
  logic [5:0]     seen_q     [pdr_pkg::PORT_SLOTS];
  logic [5:0]     explen_q   [pdr_pkg::PORT_SLOTS];
  logic [7:0]     rcrc_q     [pdr_pkg::PORT_SLOTS];

  state_e         state_q;
  logic [1:0]     pt;
  logic [7:0]     rx_b;
  logic           in_fire, port_ok;
  logic [2:0]     ph_eff, ph_n;
  logic [BCW-1:0] bc_eff, bc_n;
  logic [5:0]     seen_n, exp_n;
  logic [7:0]     crc_n;
  logic           start_fin;
  logic [AW-1:0]  in_base, waddr;

  // shared CRC unit
  logic [7:0] crc_in, crc_byte, crc_out;

  assign pt       = s_axis_tuser;
  assign rx_b     = s_axis_tdata;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire  = s_axis_tvalid & s_axis_tready;
  assign port_ok  = {1'b0, pt} < 3'(NUM_PORTS);
  assign in_base  = AW'(pt) * AW'(SLOT_LEN);
  assign waddr    = in_base + AW'(bc_eff);

  // Next parser state for the arriving byte
  always_comb begin
    ph_eff    = phase_q[pt];
    bc_eff    = bcount_q[pt];
    if (bc_eff >= BCW'(SLOT_LEN)) begin
      bc_eff = '0;
      ph_eff = pdr_pkg::PH_HEADER;
    end
    bc_n      = bc_eff + BCW'(1);
    ph_n      = ph_eff;
    seen_n    = seen_q[pt];
    exp_n     = explen_q[pt];
    crc_n     = rcrc_q[pt];
    start_fin = 1'b0;
    case (ph_eff) inside
      pdr_pkg::PH_HEADER: begin
        if (rx_b == header_q) begin
          crc_n = crc_out;
          ph_n  = pdr_pkg::PH_TARGET;
        end else begin
          bc_n = '0;
        end
      end
      pdr_pkg::PH_TARGET, pdr_pkg::PH_SOURCE, pdr_pkg::PH_TTL, pdr_pkg::PH_CMD: begin
        crc_n = crc_out;
        ph_n  = ph_eff + 3'd1;
      end
      pdr_pkg::PH_LEN: begin
        if (rx_b > 8'(MAX_DATA)) begin
          ph_n = pdr_pkg::PH_HEADER;
          bc_n = '0;
        end else begin
          crc_n  = crc_out;
          exp_n  = rx_b[5:0];
          seen_n = '0;
          ph_n   = (rx_b == 8'd0) ? pdr_pkg::PH_CRC : pdr_pkg::PH_DATA;
        end
      end
      pdr_pkg::PH_DATA: begin
        crc_n  = crc_out;
        seen_n = seen_q[pt] + 6'd1;
        if (seen_n >= explen_q[pt]) begin
          ph_n = pdr_pkg::PH_CRC;
        end
      end
      default: begin
        start_fin = (rx_b == rcrc_q[pt]);
        ph_n      = pdr_pkg::PH_HEADER;
        bc_n      = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pdr_pkg::PORT_SLOTS; i++) begin
        phase_q[i]  <= pdr_pkg::PH_HEADER;
        bcount_q[i] <= '0;
        seen_q[i]   <= '0;
        explen_q[i] <= '0;
        rcrc_q[i]   <= '0;
      end
    end else if (in_fire && port_ok) begin
      phase_q[pt]  <= ph_n;
      bcount_q[pt] <= bc_n;
      seen_q[pt]   <= seen_n;
      explen_q[pt] <= exp_n;
      rcrc_q[pt]   <= crc_n;
    end
  end

  // ---------------- emitter sequencer ----------------
  logic [AW-1:0]  base_q, raddr;
  logic [1:0]     fpt_q;
  logic [BCW-1:0] len_q, nrows_q;
  logic [5:0]     dlen_q;
  logic [1:0]     hk_q;
  logic [7:0]     hdr_q [4];
  logic [1:0]     mode_q, oport_q;
  logic [IW-1:0]  idx_q;
  logic [7:0]     ecrc_q;
  logic [7:0]     rd_data;
  logic           last_row;
  logic [7:0]     fwd_byte, rep_byte;
  logic [7:0]     tgt, snd, ttl, cmd;

  // out register fields
  logic [1:0] o_port_q, o_kind_q;
  logic [7:0] o_byte_q, o_tgt_q, o_snd_q, o_cmd_q, o_pbyte_q;
  logic [5:0] o_plen_q, o_pidx_q;
  logic       o_last_q, o_valid_q;

  assign tgt = hdr_q[0];
  assign snd = hdr_q[1];
  assign ttl = hdr_q[2];
  assign cmd = hdr_q[3];
  assign last_row = (BCW'(idx_q) + BCW'(1)) == nrows_q;

  // CRC unit input: parser while idle, emitter otherwise
  always_comb begin
    if (state_q == S_IDLE) begin
      crc_in   = (ph_eff == pdr_pkg::PH_HEADER) ? 8'd0 : rcrc_q[pt];
      crc_byte = rx_b;
    end else begin
      crc_in   = ecrc_q;
      crc_byte = o_byte_q;
    end
  end

  pdr_crc8 u_crc (
    .crc_i  (crc_in),
    .byte_i (crc_byte),
    .crc_o  (crc_out)
  );

  // Store read address
  always_comb begin
    if (state_q == S_HRD) begin
      raddr = base_q + AW'(hk_q) + AW'(1);
    end else if (mode_q == pdr_pkg::KIND_LOCAL) begin
      raddr = base_q + AW'(idx_q) + AW'(6);
    end else begin
      raddr = base_q + AW'(idx_q);
    end
  end

  pdr_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk_i   (clk_i),
    .we_i    (in_fire && port_ok),
    .waddr_i (waddr),
    .wdata_i (rx_b),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  // Forwarded byte: TTL lowered, CRC replaced
  always_comb begin
    if (last_row) begin
      fwd_byte = ecrc_q;
    end else if (idx_q == IW'(3)) begin
      fwd_byte = ttl - 8'd1;
    end else begin
      fwd_byte = rd_data;
    end
  end

  // Error reply byte
  always_comb begin
    case (idx_q)
      IW'(0):  rep_byte = header_q;
      IW'(1):  rep_byte = snd;
      IW'(2):  rep_byte = node_id_q;
      IW'(3):  rep_byte = reply_ttl_q;
      IW'(4):  rep_byte = err_cmd_q;
      IW'(5):  rep_byte = pdr_pkg::REPLY_LEN;
      IW'(6):  rep_byte = cmd;
      IW'(7):  rep_byte = ttl_code_q;
      default: rep_byte = ecrc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      o_valid_q <= 1'b0;
      hk_q      <= '0;
      idx_q     <= '0;
      mode_q    <= pdr_pkg::KIND_LOCAL;
      nrows_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_fire && port_ok && start_fin) begin
            base_q <= in_base;
            fpt_q  <= pt;
            len_q  <= bc_n == '0 ? bc_eff + BCW'(1) : bc_n;
            dlen_q <= explen_q[pt];
            hk_q   <= '0;
            state_q <= S_HRD;
          end
        end
        S_HRD: state_q <= S_HLAT;
        S_HLAT: begin
          hdr_q[hk_q] <= rd_data;
          hk_q        <= hk_q + 2'd1;
          state_q     <= (hk_q == 2'd3) ? S_DECIDE : S_HRD;
        end
        S_DECIDE: begin
          idx_q  <= '0;
          ecrc_q <= '0;
          if (tgt == node_id_q || tgt == bcast_q) begin
            mode_q  <= pdr_pkg::KIND_LOCAL;
            oport_q <= 2'd0;
            nrows_q <= (dlen_q == 6'd0) ? BCW'(1) : BCW'(dlen_q);
            state_q <= S_RD;
          end else if (fpt_q == 2'd3) begin
            state_q <= S_IDLE;
          end else if (ttl == 8'd0) begin
            if (cmd == err_cmd_q || MAX_DATA < 2) begin
              state_q <= S_IDLE;
            end else begin
              mode_q  <= pdr_pkg::KIND_REPLY;
              oport_q <= fpt_q;
              nrows_q <= BCW'(9);
              state_q <= S_RD;
            end
          end else begin
            mode_q  <= pdr_pkg::KIND_FWD;
            oport_q <= (fpt_q == 2'd1) ? 2'd2 : 2'd1;
            nrows_q <= len_q;
            state_q <= S_RD;
          end
        end
        S_RD: state_q <= S_LAT;
        S_LAT: begin
          o_kind_q  <= mode_q;
          o_port_q  <= oport_q;
          o_last_q  <= last_row;
          o_tgt_q   <= 8'd0;
          o_snd_q   <= 8'd0;
          o_cmd_q   <= 8'd0;
          o_plen_q  <= 6'd0;
          o_pidx_q  <= 6'd0;
          o_pbyte_q <= 8'd0;
          o_byte_q  <= 8'd0;
          case (mode_q)
            pdr_pkg::KIND_LOCAL: begin
              o_tgt_q   <= tgt;
              o_snd_q   <= snd;
              o_cmd_q   <= cmd;
              o_plen_q  <= dlen_q;
              o_pidx_q  <= 6'(idx_q);
              o_pbyte_q <= (dlen_q == 6'd0) ? 8'd0 : rd_data;
            end
            pdr_pkg::KIND_FWD: o_byte_q <= fwd_byte;
            default:           o_byte_q <= rep_byte;
          endcase
          o_valid_q <= 1'b1;
          state_q   <= S_OUT;
        end
        S_OUT: begin
          if (m_axis_tready) begin
            o_valid_q <= 1'b0;
            ecrc_q    <= crc_out;
            idx_q     <= idx_q + IW'(1);
            state_q   <= o_last_q ? S_IDLE : S_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // ---------------- result port ----------------
  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tuser  = o_kind_q;
  assign m_axis_tlast  = o_last_q;
  assign m_axis_tdata  = {2'b00, o_pbyte_q, o_pidx_q, o_plen_q, o_cmd_q,
                          o_snd_q, o_tgt_q, o_byte_q, o_port_q};

endmodule

### hw/rtl/pdr_checker.sv
// ----------------------------------------------------------------------------
// pdr_checker
// Port-level checks of the packet deframer/router, bound to the top level.
// ----------------------------------------------------------------------------
`include "packet_deframer_router_top_defines.svh"

module pdr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        pready
);

  logic stalled, is_local, is_tx;

  assign stalled  = m_axis_tvalid && !m_axis_tready;
  assign is_local = m_axis_tvalid && (m_axis_tuser == pdr_pkg::KIND_LOCAL);
  assign is_tx    = m_axis_tvalid && (m_axis_tuser != pdr_pkg::KIND_LOCAL);

  // A stalled word holds its contents
  `PDR_ASSERT(a_out_hold, clk_i, rst_ni, stalled |=> m_axis_tvalid && $stable(m_axis_tdata))

  // No input is taken while a result word is pending
  `PDR_ASSERT(a_no_overlap, clk_i, rst_ni, m_axis_tvalid |-> !s_axis_tready)

  // Local delivery words carry no transmit port or byte
  `PDR_ASSERT(a_local_clean, clk_i, rst_ni, is_local |-> m_axis_tdata[9:0] == 10'd0)

  // Forwarded and reply words carry no delivery header
  `PDR_ASSERT(a_tx_clean, clk_i, rst_ni, is_tx |-> m_axis_tdata[55:10] == 46'd0)

  // Register port never waits
  `PDR_ASSERT_ALWAYS(a_pready, clk_i, pready)

endmodule

bind packet_deframer_router_top pdr_checker u_pdr_checker (.*);
